[sv/sjfk_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sjfk_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int NUM_JOINTS     = 6;
    localparam int CFG_W          = 18;
    localparam int CFG_IDX_W      = 3;
    localparam int Q_BITS         = 30;

    // odd polynomial for sin(pi/2 * x), x in q30
    localparam logic [Q_BITS:0] SIN_COEF [5] = '{
        31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026990, 31'd172272
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_HEIGHT      = 3'd0,
        CFG_UPPER_ARM_LENGTH = 3'd1,
        CFG_FOREARM_LENGTH   = 3'd2,
        CFG_WRIST1_OFFSET    = 3'd3,
        CFG_WRIST2_OFFSET    = 3'd4,
        CFG_WRIST3_OFFSET    = 3'd5
    } t_cfg_idx;

    localparam logic signed [CFG_W-1:0] RST_BASE_HEIGHT      = 18'sd10650;
    localparam logic signed [CFG_W-1:0] RST_UPPER_ARM_LENGTH = -18'sd27853;
    localparam logic signed [CFG_W-1:0] RST_FOREARM_LENGTH   = -18'sd25703;
    localparam logic signed [CFG_W-1:0] RST_WRIST1_OFFSET    = 18'sd8736;
    localparam logic signed [CFG_W-1:0] RST_WRIST2_OFFSET    = 18'sd6534;
    localparam logic signed [CFG_W-1:0] RST_WRIST3_OFFSET    = 18'sd6527;

    // joint frame layouts: planar, twist with -1 in row 1, twist with +1 in row 1
    typedef enum logic [1:0] {
        KIND_PLANAR,
        KIND_TWIST_NEG,
        KIND_TWIST_POS
    } t_kind;

    function automatic int rot_width(input int frac);
        return frac + 4;
    endfunction

    function automatic int pos_width(input int frac);
        return (CFG_W + 8 > frac + 6) ? CFG_W + 8 : frac + 6;
    endfunction

endpackage

`default_nettype wire

[sv/sjfk_sincos.sv]
`timescale 1ns / 1ps
`default_nettype none

module sjfk_sincos #(
    parameter int ANGLE_BITS = sjfk_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = sjfk_pkg::FRAC_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic [ANGLE_BITS-1:0]   i_angle,
    output logic signed [FRAC_BITS+1:0]  o_sin,
    output logic signed [FRAC_BITS+1:0]  o_cos
);
    import sjfk_pkg::*;

    localparam int FB = ANGLE_BITS - 2;
    localparam int XW = Q_BITS + 1;
    localparam int SW = FRAC_BITS + 2;
    localparam int MG = FRAC_BITS + 1;
    localparam logic [XW-1:0] ONE_Q = XW'(1) << Q_BITS;
    localparam logic [XW:0] RND_Q = (XW + 1)'(1) << (Q_BITS - FRAC_BITS - 1);
    localparam logic [XW:0] MAG_LIM = (XW + 1)'(1) << FRAC_BITS;

    typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} t_quad;

    function automatic logic [XW:0] mul_q(input logic [XW-1:0] a, input logic [XW-1:0] b);
        logic [2*XW-1:0] m;
        m = a * b;
        return m[2*XW-1:Q_BITS];
    endfunction

    logic [XW-1:0] w_f;
    logic [XW-1:0] w_x  [2];
    logic [XW-1:0] n_x2 [2];
    logic [XW-1:0] n_p  [4][2];
    logic [XW:0]   n_s  [2];
    logic [XW:0]   w_rs [2];
    logic [MG-1:0] w_mag [2];
    logic signed [SW-1:0] w_pos [2];
    logic signed [SW-1:0] n_sin, n_cos;

    logic [XW-1:0] r_x  [5][2];
    logic [XW-1:0] r_x2 [4][2];
    logic [XW-1:0] r_p  [4][2];
    logic [XW:0]   r_s  [2];
    logic [1:0]    r_q  [6];

    always_comb begin
        w_f = XW'(i_angle[FB-1:0]) << (Q_BITS - FB);
        w_x[0] = w_f;
        w_x[1] = ONE_Q - w_f;
        for (int g = 0; g < 2; g++) begin
            n_x2[g] = XW'(mul_q(w_x[g], w_x[g]));
            for (int k = 0; k < 4; k++) begin
                n_p[k][g] = XW'({1'b0, SIN_COEF[3-k]}
                    - mul_q((k == 0) ? SIN_COEF[4] : r_p[(k == 0) ? 0 : k-1][g],
                            r_x2[k][g]));
            end
            n_s[g] = mul_q(r_p[3][g], r_x[4][g]);
            w_rs[g] = (r_s[g] + RND_Q) >> (Q_BITS - FRAC_BITS);
            w_mag[g] = (w_rs[g] > MAG_LIM) ? MG'(MAG_LIM) : MG'(w_rs[g]);
            w_pos[g] = $signed({1'b0, w_mag[g]});
        end
        unique case (t_quad'(r_q[5]))
            QUAD_0: begin n_sin = w_pos[0];  n_cos = w_pos[1];  end
            QUAD_1: begin n_sin = w_pos[1];  n_cos = -w_pos[0]; end
            QUAD_2: begin n_sin = -w_pos[0]; n_cos = -w_pos[1]; end
            QUAD_3: begin n_sin = -w_pos[1]; n_cos = w_pos[0];  end
            default: begin n_sin = w_pos[0]; n_cos = w_pos[1]; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_angle[ANGLE_BITS-1:ANGLE_BITS-2];
            for (int k = 1; k < 6; k++) r_q[k] <= r_q[k-1];
            for (int g = 0; g < 2; g++) begin
                r_x[0][g]  <= w_x[g];
                r_x2[0][g] <= n_x2[g];
                for (int k = 1; k < 5; k++) r_x[k][g] <= r_x[k-1][g];
                for (int k = 1; k < 4; k++) r_x2[k][g] <= r_x2[k-1][g];
                for (int k = 0; k < 4; k++) r_p[k][g] <= n_p[k][g];
                r_s[g] <= n_s[g];
            end
            o_sin <= n_sin;
            o_cos <= n_cos;
        end
    end

endmodule

`default_nettype wire

[sv/sjfk_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module sjfk_cell #(
    parameter int              FRAC_BITS = sjfk_pkg::FRAC_BITS_DEF,
    parameter sjfk_pkg::t_kind KIND      = sjfk_pkg::KIND_PLANAR,
    localparam int RW = sjfk_pkg::rot_width(FRAC_BITS),
    localparam int PW = sjfk_pkg::pos_width(FRAC_BITS),
    localparam int CW = sjfk_pkg::CFG_W + 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic signed [FRAC_BITS+1:0] i_sin,
    input  wire logic signed [FRAC_BITS+1:0] i_cos,
    input  wire logic signed [CW-1:0]    i_off [3],
    input  wire logic signed [RW-1:0]    i_r [3][3],
    input  wire logic signed [PW-1:0]    i_p [3],
    output logic signed [RW-1:0]         o_r [3][3],
    output logic signed [PW-1:0]         o_p [3]
);
    import sjfk_pkg::*;

    localparam int MW = RW + 1 + FRAC_BITS + 2;
    localparam int QW = RW + CW;
    localparam logic signed [MW:0]   RND_R = (MW + 1)'(2 ** (FRAC_BITS - 1));
    localparam logic signed [QW+1:0] RND_P = (QW + 2)'(2 ** (FRAC_BITS - 1));

    logic signed [RW:0] w_a0 [3], w_u [3], w_t2 [3];
    logic signed [MW:0] w_s0 [3], w_s1 [3];
    logic signed [QW+1:0] w_ps [3];

    logic signed [MW-1:0] r_m00 [3], r_m01 [3], r_m10 [3], r_m11 [3];
    logic signed [QW-1:0] r_q0 [3], r_q1 [3], r_q2 [3];
    logic signed [RW:0]   r_t2 [3];
    logic signed [PW-1:0] r_pa [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_a0[i] = (RW + 1)'(i_r[i][0]);
            unique case (KIND)
                KIND_PLANAR: begin
                    w_u[i]  = (RW + 1)'(i_r[i][1]);
                    w_t2[i] = (RW + 1)'(i_r[i][2]);
                end
                KIND_TWIST_NEG: begin
                    w_u[i]  = (RW + 1)'(i_r[i][2]);
                    w_t2[i] = -((RW + 1)'(i_r[i][1]));
                end
                default: begin
                    w_u[i]  = -((RW + 1)'(i_r[i][2]));
                    w_t2[i] = (RW + 1)'(i_r[i][1]);
                end
            endcase
            w_s0[i] = (MW + 1)'(r_m00[i]) + (MW + 1)'(r_m01[i]) + RND_R;
            w_s1[i] = (MW + 1)'(r_m10[i]) - (MW + 1)'(r_m11[i]) + RND_R;
            w_ps[i] = (QW + 2)'(r_q0[i]) + (QW + 2)'(r_q1[i]) + (QW + 2)'(r_q2[i]) + RND_P;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_m00[i] <= w_a0[i] * i_cos;
                r_m01[i] <= w_u[i] * i_sin;
                r_m10[i] <= w_u[i] * i_cos;
                r_m11[i] <= w_a0[i] * i_sin;
                r_q0[i]  <= i_r[i][0] * i_off[0];
                r_q1[i]  <= i_r[i][1] * i_off[1];
                r_q2[i]  <= i_r[i][2] * i_off[2];
                r_t2[i]  <= w_t2[i];
                r_pa[i]  <= i_p[i];
                o_r[i][0] <= RW'(w_s0[i] >>> FRAC_BITS);
                o_r[i][1] <= RW'(w_s1[i] >>> FRAC_BITS);
                o_r[i][2] <= RW'(r_t2[i]);
                o_p[i]    <= PW'(w_ps[i] >>> FRAC_BITS) + r_pa[i];
            end
        end
    end

endmodule

`default_nettype wire

[sv/six_joint_forward_kinematics_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// six joint forward kinematics, one joint vector in, one end-effector pose out
// input channel i_s_*: six joint angles, binary angle (full turn = 2^ANGLE_BITS)
// output channel o_m_*: position x, y, z and row-major 3x3 rotation, saturated
// config port: i_cfg_we, i_cfg_addr, i_cfg_wdata; link offsets, index 0 to 5,
//   other indexes ignored; write only while no item is in flight
// structure: six sine/cosine pipelines feed a row of five cells,
//   each folding one joint frame into the running transform,
//   then a saturation stage and a two-entry output buffer
// throughput: one item per cycle while o_s_tready is high, set by the fully pipelined cells
// reset: clears the pipeline valid flags and the buffer, loads default link offsets
// stall: the output buffer keeps taking items while one result waits; once
//   both entries are full and i_m_tready is low, the whole pipeline holds and o_s_tready drops
module six_joint_forward_kinematics_unit #(
    parameter int ANGLE_BITS = sjfk_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = sjfk_pkg::FRAC_BITS_DEF,
    localparam int IN_W  = ((sjfk_pkg::NUM_JOINTS * ANGLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((3 * (FRAC_BITS + 4) + 9 * (FRAC_BITS + 2) + 7) / 8) * 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // joint1_angle .. joint6_angle
    input  wire logic [IN_W-1:0]                   i_s_tdata,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // pos_x, pos_y, pos_z, rot_r0c0 .. rot_r2c2
    output logic [OUT_W-1:0]                       o_m_tdata,
    input  wire logic                              i_cfg_we,
    input  wire logic [sjfk_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire logic [sjfk_pkg::CFG_W-1:0]        i_cfg_wdata
);
    import sjfk_pkg::*;

    localparam int RW  = rot_width(FRAC_BITS);
    localparam int PW  = pos_width(FRAC_BITS);
    localparam int CW  = CFG_W + 1;
    localparam int SW  = FRAC_BITS + 2;
    localparam int POW = FRAC_BITS + 4;
    localparam int LAT = 18;
    localparam logic signed [PW-1:0] POS_LIM = PW'(4 * (2 ** FRAC_BITS));
    localparam logic signed [RW-1:0] ROT_LIM = RW'(2 ** FRAC_BITS);

    logic signed [CFG_W-1:0] r_cfg [NUM_JOINTS];
    logic [LAT-1:0]   r_v;
    logic [OUT_W-1:0] r_word, r_head, r_spare;
    logic [1:0]       r_count;
    logic             w_en, w_push, w_pop;
    logic [OUT_W-1:0] n_word;

    logic signed [SW-1:0] w_sin [NUM_JOINTS], w_cos [NUM_JOINTS];
    logic signed [SW-1:0] w_dsin [1:NUM_JOINTS-1], w_dcos [1:NUM_JOINTS-1];
    logic signed [CW-1:0] w_off [1:NUM_JOINTS-1][3];
    logic signed [RW-1:0] w_acc_r [NUM_JOINTS][3][3];
    logic signed [PW-1:0] w_acc_p [NUM_JOINTS][3];

    assign w_pop      = (r_count != 2'd0) && i_m_tready;
    assign w_en       = (r_count != 2'd2) || i_m_tready;
    assign w_push     = w_en && r_v[LAT-1];
    assign o_s_tready = w_en;
    assign o_m_tvalid = (r_count != 2'd0);
    assign o_m_tdata  = r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[CFG_BASE_HEIGHT]      <= RST_BASE_HEIGHT;
            r_cfg[CFG_UPPER_ARM_LENGTH] <= RST_UPPER_ARM_LENGTH;
            r_cfg[CFG_FOREARM_LENGTH]   <= RST_FOREARM_LENGTH;
            r_cfg[CFG_WRIST1_OFFSET]    <= RST_WRIST1_OFFSET;
            r_cfg[CFG_WRIST2_OFFSET]    <= RST_WRIST2_OFFSET;
            r_cfg[CFG_WRIST3_OFFSET]    <= RST_WRIST3_OFFSET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_BASE_HEIGHT:      r_cfg[CFG_BASE_HEIGHT]      <= i_cfg_wdata;
                CFG_UPPER_ARM_LENGTH: r_cfg[CFG_UPPER_ARM_LENGTH] <= i_cfg_wdata;
                CFG_FOREARM_LENGTH:   r_cfg[CFG_FOREARM_LENGTH]   <= i_cfg_wdata;
                CFG_WRIST1_OFFSET:    r_cfg[CFG_WRIST1_OFFSET]    <= i_cfg_wdata;
                CFG_WRIST2_OFFSET:    r_cfg[CFG_WRIST2_OFFSET]    <= i_cfg_wdata;
                CFG_WRIST3_OFFSET:    r_cfg[CFG_WRIST3_OFFSET]    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // angle units
    for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_trig
        sjfk_sincos #(
            .ANGLE_BITS (ANGLE_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_sincos (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_angle (i_s_tdata[j*ANGLE_BITS +: ANGLE_BITS]),
            .o_sin   (w_sin[j]),
            .o_cos   (w_cos[j])
        );
    end

    // line up each joint's sine and cosine with its cell
    for (genvar j = 1; j < NUM_JOINTS; j++) begin : g_align
        localparam int D = 2 * (j - 1);
        if (D == 0) begin : g_direct
            assign w_dsin[j] = w_sin[j];
            assign w_dcos[j] = w_cos[j];
        end else begin : g_delay
            logic signed [SW-1:0] r_ds [D];
            logic signed [SW-1:0] r_dc [D];
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_ds[0] <= w_sin[j];
                    r_dc[0] <= w_cos[j];
                    for (int k = 1; k < D; k++) begin
                        r_ds[k] <= r_ds[k-1];
                        r_dc[k] <= r_dc[k-1];
                    end
                end
            end
            assign w_dsin[j] = r_ds[D-1];
            assign w_dcos[j] = r_dc[D-1];
        end
    end

    always_comb begin
        for (int j = 1; j < NUM_JOINTS; j++)
            for (int k = 0; k < 3; k++) w_off[j][k] = '0;
        w_off[2][0] = CW'(r_cfg[CFG_UPPER_ARM_LENGTH]);
        w_off[3][0] = CW'(r_cfg[CFG_FOREARM_LENGTH]);
        w_off[3][2] = CW'(r_cfg[CFG_WRIST1_OFFSET]);
        w_off[4][1] = -(CW'(r_cfg[CFG_WRIST2_OFFSET]));
        w_off[5][1] = CW'(r_cfg[CFG_WRIST3_OFFSET]);
    end

    // base frame straight from the first joint
    always_comb begin
        w_acc_r[0][0][0] = RW'(w_cos[0]);
        w_acc_r[0][0][1] = -(RW'(w_sin[0]));
        w_acc_r[0][0][2] = '0;
        w_acc_r[0][1][0] = RW'(w_sin[0]);
        w_acc_r[0][1][1] = RW'(w_cos[0]);
        w_acc_r[0][1][2] = '0;
        w_acc_r[0][2][0] = '0;
        w_acc_r[0][2][1] = '0;
        w_acc_r[0][2][2] = ROT_LIM;
        w_acc_p[0][0]    = '0;
        w_acc_p[0][1]    = '0;
        w_acc_p[0][2]    = PW'(r_cfg[CFG_BASE_HEIGHT]);
    end

    for (genvar j = 1; j < NUM_JOINTS; j++) begin : g_chain
        localparam t_kind K = (j == 1 || j == 4) ? KIND_TWIST_NEG :
                              ((j == 5) ? KIND_TWIST_POS : KIND_PLANAR);
        sjfk_cell #(
            .FRAC_BITS (FRAC_BITS),
            .KIND      (K)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_sin (w_dsin[j]),
            .i_cos (w_dcos[j]),
            .i_off (w_off[j]),
            .i_r   (w_acc_r[j-1]),
            .i_p   (w_acc_p[j-1]),
            .o_r   (w_acc_r[j]),
            .o_p   (w_acc_p[j])
        );
    end

    // saturate and pack
    always_comb begin
        logic signed [PW-1:0] pv;
        logic signed [RW-1:0] rv;
        n_word = '0;
        for (int i = 0; i < 3; i++) begin
            pv = w_acc_p[NUM_JOINTS-1][i];
            if (pv > POS_LIM) pv = POS_LIM;
            else if (pv < -POS_LIM) pv = -POS_LIM;
            n_word[i*POW +: POW] = POW'(pv);
        end
        for (int i = 0; i < 9; i++) begin
            rv = w_acc_r[NUM_JOINTS-1][i/3][i%3];
            if (rv > ROT_LIM) rv = ROT_LIM;
            else if (rv < -ROT_LIM) rv = -ROT_LIM;
            n_word[3*POW + i*SW +: SW] = SW'(rv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_word <= n_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_count <= 2'd0;
        end else begin
            if (w_en) r_v <= {r_v[LAT-2:0], i_s_tvalid};
            priority if (w_push && w_pop) begin
                if (r_count == 2'd1) begin
                    r_head <= r_word;
                end else begin
                    r_head  <= r_spare;
                    r_spare <= r_word;
                end
            end else if (w_pop) begin
                r_head  <= r_spare;
                r_count <= r_count - 2'd1;
            end else if (w_push) begin
                if (r_count == 2'd0) r_head <= r_word;
                else r_spare <= r_word;
                r_count <= r_count + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire
